>>> rtl/gha_pkg.sv
// Shared types, operation and status codes for the generational handle allocator.
package gha_pkg;

  localparam int SLOTS_DEF = 1024;
  localparam int SLOT_W    = 10;
  localparam int SEQ_W     = 32;
  localparam int ENT_W     = 32;
  localparam int OP_W      = 2;
  localparam int STAT_W    = 3;

  localparam logic [ENT_W-1:0] NO_ENTITY = '1;
  localparam logic [SEQ_W-1:0] SEQ_FIRST = SEQ_W'(1);

  localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd1;
  localparam logic [OP_W-1:0] OP_DESTROY = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_STALE     = 3'd1;
  localparam logic [STAT_W-1:0] ST_RANGE     = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] ST_FREE      = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ENT_W-1:0]  entity_in;
    logic [SLOT_W-1:0] slot_in;
    logic [SEQ_W-1:0]  seq_in;
  } gha_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_out;
    logic [SEQ_W-1:0]  seq_out;
    logic [ENT_W-1:0]  entity_out;
    logic [STAT_W-1:0] status;
  } gha_out_t;

  typedef struct packed {
    logic              alive;
    logic [SEQ_W-1:0]  seq;
    logic [ENT_W-1:0]  entity;
  } gha_entry_t;

endpackage

>>> rtl/gha_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
module gha_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/generational_handle_allocator.sv
// Generational handle allocator: slot table and LIFO free stack in block RAM.
//
//   channel  | signals                          | direction
//   ---------+----------------------------------+----------
//   input    | in_valid, in_stall, in_data      | in
//   result   | out_valid, out_stall, out_data   | out
//
// Each transaction has an accept and an execute step: the accept edge reads the slot table and
// the top of the free stack, the execute edge updates both RAMs and loads the result.
// One transaction is in flight at a time; the RAM read-modify-write sets the rate.
// A result held by out_stall still lets one more transaction in; its execute cycle
// then waits, and in_stall stays high until the held result is taken.
// Synchronous reset empties the table and stack by clearing the counters only.
module generational_handle_allocator
  import gha_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  gha_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output gha_out_t out_data
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int XW = (CW > SLOT_W) ? CW : SLOT_W;
  localparam int SW = SEQ_W + IW;
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic              state_r, state_nxt;
  logic [CW-1:0]     used_r, used_nxt;
  logic [CW-1:0]     free_r, free_nxt;
  logic              out_valid_r, out_valid_nxt;
  gha_out_t          out_r, out_nxt;

  logic [OP_W-1:0]   op_r;
  logic [ENT_W-1:0]  ent_r;
  logic [XW-1:0]     slot_r;
  logic [SEQ_W-1:0]  seq_r;

  logic              accept;
  logic              exec_go;
  logic [XW-1:0]     slot_in_x;
  logic [CW-1:0]     free_dec;

  logic              tbl_we;
  logic [IW-1:0]     tbl_waddr;
  gha_entry_t        tbl_wdata;
  gha_entry_t        tbl_q;
  logic              stk_we;
  logic [SW-1:0]     stk_wdata;
  logic [SW-1:0]     stk_q;
  logic              in_range;
  logic [SEQ_W-1:0]  seq_inc;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign exec_go   = (state_r == S_EXEC) && (!out_valid_r || !out_stall);
  assign slot_in_x = XW'(in_data.slot_in);
  assign free_dec  = free_r - CW'(1);

  gha_ram #(
    .DEPTH (SLOTS),
    .WIDTH ($bits(gha_entry_t))
  ) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (accept),
    .raddr (slot_in_x[IW-1:0]),
    .rdata (tbl_q)
  );

  // stack entry carries the slot's next sequence, so a pop needs no table read
  gha_ram #(
    .DEPTH (SLOTS),
    .WIDTH (SW)
  ) u_stk (
    .clk   (clk),
    .we    (stk_we),
    .waddr (free_r[IW-1:0]),
    .wdata (stk_wdata),
    .re    (accept),
    .raddr (free_dec[IW-1:0]),
    .rdata (stk_q)
  );

  assign in_range = (slot_r < XW'(used_r));
  assign seq_inc  = tbl_q.seq + SEQ_W'(1);

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_data.op;
      ent_r  <= in_data.entity_in;
      slot_r <= slot_in_x;
      seq_r  <= in_data.seq_in;
    end
    if (exec_go) begin
      out_r <= out_nxt;
    end
  end

  always_comb begin
    used_nxt  = used_r;
    free_nxt  = free_r;
    tbl_we    = 1'b0;
    tbl_waddr = slot_r[IW-1:0];
    tbl_wdata = '{alive: 1'b1, seq: SEQ_FIRST, entity: ent_r};
    stk_we    = 1'b0;
    stk_wdata = {seq_inc, slot_r[IW-1:0]};
    out_nxt   = '{slot_out: '0, seq_out: '0, entity_out: '0, status: ST_OK};
    unique case (op_r)
      OP_CREATE: begin
        if (free_r != '0) begin
          tbl_we             = exec_go;
          tbl_waddr          = stk_q[IW-1:0];
          tbl_wdata.seq      = stk_q[SW-1:IW];
          free_nxt           = free_dec;
          out_nxt.slot_out   = SLOT_W'(XW'(stk_q[IW-1:0]));
          out_nxt.seq_out    = stk_q[SW-1:IW];
          out_nxt.entity_out = ent_r;
        end else if (used_r < SLOTS_C) begin
          tbl_we             = exec_go;
          tbl_waddr          = used_r[IW-1:0];
          used_nxt           = used_r + CW'(1);
          out_nxt.slot_out   = SLOT_W'(XW'(used_r));
          out_nxt.seq_out    = SEQ_FIRST;
          out_nxt.entity_out = ent_r;
        end else begin
          out_nxt.entity_out = NO_ENTITY;
          out_nxt.status     = ST_FULL;
        end
      end
      OP_LOOKUP: begin
        if (!in_range) begin
          out_nxt.entity_out = NO_ENTITY;
          out_nxt.status     = ST_RANGE;
        end else if (tbl_q.seq != seq_r) begin
          out_nxt.entity_out = NO_ENTITY;
          out_nxt.status     = ST_STALE;
        end else begin
          out_nxt.entity_out = tbl_q.entity;
        end
      end
      OP_DESTROY: begin
        if (!in_range) begin
          out_nxt.entity_out = NO_ENTITY;
          out_nxt.status     = ST_RANGE;
        end else if (!tbl_q.alive) begin
          out_nxt.status = ST_FREE;
        end else if (free_r < SLOTS_C) begin
          tbl_we    = exec_go;
          tbl_wdata = '{alive: 1'b0, seq: seq_inc, entity: '0};
          stk_we    = exec_go;
          free_nxt  = free_r + CW'(1);
        end else begin
          out_nxt.status = ST_FULL;
        end
      end
      OP_CLEAR: begin
        used_nxt = '0;
        free_nxt = '0;
      end
      default: begin
        out_nxt.status = ST_OK;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_EXEC;
      S_EXEC: begin
        if (exec_go) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      free_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec_go) begin
        used_r <= used_nxt;
        free_r <= free_nxt;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // every freed slot was appended earlier
  a_free_le_used: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= used_r) else $error("free stack deeper than slots in use");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= SLOTS_C) else $error("slot count beyond table size");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC)) else $error("accepted transaction not executed");

  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("executed transaction gave no result");

  a_write_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (tbl_we || stk_we) |-> exec_go) else $error("RAM write outside execute cycle");

endmodule
